// ----- design/nps_pkg.sv -----
// Shared types and constants for the nearest point search block.
`default_nettype none

package nps_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Fixed field widths of the beats and the register.
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned DIST_W  = 33;

  // Largest reportable squared distance; larger values saturate here.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  // Largest difference whose square is formed; above it the square saturates.
  localparam logic [DIST_W-1:0] DIFF_LIM = 33'h0_FFFF_FFFF;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = '0;
  localparam logic [COUNT_W-1:0]   POINT_COUNT_RST = 7'd1;

  // Input beat kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] nearest_slot;
    logic [DIST_W-1:0] nearest_dist_sq;
  } out_item_t;

  // Travels with each point through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } scan_tag_t;

endpackage

`default_nettype wire

// ----- design/nearest_point_search.sv -----
// Nearest point search: squared-Euclidean linear scan over a RAM-held point store.
// A write beat stores one point; the block is ready again the next cycle.
// A query beat scans slots 0..N-1 (N = point_count clamped to 1..MAX_POINTS), one RAM
// read per cycle; the distances then pass through the distance pipeline and the running
// minimum into the output register, and the next beat is taken once the result is loaded. An unread result
// delays the next one. Reset sets point_count to 1 and empties the output register.
`default_nettype none

module nearest_point_search #(
  parameter int unsigned MAX_POINTS  = nps_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel.
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire nps_pkg::in_item_t              in_data,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output nps_pkg::out_item_t                  out_data,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [nps_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [nps_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [nps_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned CNTW = (AW + 1 > nps_pkg::COUNT_W) ? AW + 1 : nps_pkg::COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------------
  // Configuration register. The user must write it only while the block is idle;
  // this is not enforced. The count is sampled once per query, at query acceptance.
  // ---------------------------------------------------------------------------
  logic [nps_pkg::COUNT_W-1:0]   point_count_r;
  logic [nps_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  assign reg_idx = paddr[nps_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (reg_idx == nps_pkg::REG_POINT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= nps_pkg::POINT_COUNT_RST;
    end else if (cfg_wr) begin
      point_count_r <= pwdata[nps_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == nps_pkg::REG_POINT_COUNT) begin
      prdata = nps_pkg::APB_DATA_W'(point_count_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode. Coordinates come from the low COORD_WIDTH bits of the fields
  // and are read as signed values of that width.
  // ---------------------------------------------------------------------------
  logic                   in_fire;
  logic                   is_write;
  logic                   is_query;
  logic                   slot_ok;
  logic [COORD_WIDTH-1:0] in_x;
  logic [COORD_WIDTH-1:0] in_y;
  logic [CNTW-1:0]        cnt_ext;
  logic [AW-1:0]          last_idx;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_write = in_fire && (in_data.kind == nps_pkg::KIND_WRITE);
  assign is_query = in_fire && (in_data.kind == nps_pkg::KIND_QUERY);
  assign slot_ok  = (32'(in_data.slot) < MAX_POINTS);
  assign in_x     = COORD_WIDTH'($unsigned(in_data.coord_x));
  assign in_y     = COORD_WIDTH'($unsigned(in_data.coord_y));

  // A count of zero scans one slot; a count past the store scans all of it.
  assign cnt_ext  = CNTW'(point_count_r);
  always_comb begin
    if (cnt_ext == '0) begin
      last_idx = '0;
    end else if (32'(cnt_ext) > MAX_POINTS) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(cnt_ext - 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Point store: x and y in two RAMs sharing one address. Writes happen only in
  // the idle state and reads only while scanning, so an entry is never read and
  // written in overlapping cycles and no forwarding path is needed.
  // ---------------------------------------------------------------------------
  logic                          rd_en;
  logic [AW-1:0]                 idx_r;
  logic [AW-1:0]                 last_r;
  logic signed [COORD_WIDTH-1:0] qx_r, qy_r;
  logic [COORD_WIDTH-1:0]        px_rd, py_rd;

  assign rd_en = (state_r == ST_SCAN);

  nps_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (MAX_POINTS)
  ) u_ram_x (
    .clk   (clk),
    .we    (is_write && slot_ok),
    .waddr (AW'(in_data.slot)),
    .wdata (in_x),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (px_rd)
  );

  nps_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (MAX_POINTS)
  ) u_ram_y (
    .clk   (clk),
    .we    (is_write && slot_ok),
    .waddr (AW'(in_data.slot)),
    .wdata (in_y),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (py_rd)
  );

  // The tag and slot index follow the read into the next cycle to line up with the data.
  nps_pkg::scan_tag_t rd_tag_r;
  logic [AW-1:0]      rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r.valid <= rd_en;
      rd_tag_r.last  <= rd_en && (idx_r == last_r);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (is_query) begin
      qx_r   <= $signed(in_x);
      qy_r   <= $signed(in_y);
      last_r <= last_idx;
    end
  end

  // Scan address counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (is_query) begin
      idx_r <= '0;
    end else if (rd_en) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Distance pipeline and running minimum. Slot 0 always loads the minimum; a
  // later slot replaces it only when strictly closer, so ties keep the lower slot.
  // ---------------------------------------------------------------------------
  nps_pkg::scan_tag_t          d_tag;
  logic [AW-1:0]               d_idx;
  logic [nps_pkg::DIST_W-1:0]  d_dist;
  logic [AW-1:0]               best_idx_r;
  logic [nps_pkg::DIST_W-1:0]  best_dist_r;

  nps_dist #(
    .COORD_WIDTH (COORD_WIDTH),
    .IDX_W       (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .qx       (qx_r),
    .qy       (qy_r),
    .px       ($signed(px_rd)),
    .py       ($signed(py_rd)),
    .tag_in   (rd_tag_r),
    .idx_in   (rd_idx_r),
    .tag_out  (d_tag),
    .idx_out  (d_idx),
    .dist_out (d_dist)
  );

  always_ff @(posedge clk) begin
    if (d_tag.valid && ((d_idx == '0) || (d_dist < best_dist_r))) begin
      best_idx_r  <= d_idx;
      best_dist_r <= d_dist;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_r == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (d_tag.valid && d_tag.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It holds a finished result while the next beats are taken.
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  nps_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.nearest_slot    <= nps_pkg::SLOT_W'(best_idx_r);
      out_data_r.nearest_dist_sq <= best_dist_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/nps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module nps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/nps_dist.sv -----
// Three-stage squared-distance pipeline: absolute differences, squares, saturating sum.
`default_nettype none

module nps_dist #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned IDX_W       = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic signed [COORD_WIDTH-1:0] qx,
  input  wire logic signed [COORD_WIDTH-1:0] qy,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  input  wire nps_pkg::scan_tag_t            tag_in,
  input  wire logic [IDX_W-1:0]              idx_in,
  output nps_pkg::scan_tag_t                 tag_out,
  output logic [IDX_W-1:0]                   idx_out,
  output logic [nps_pkg::DIST_W-1:0]         dist_out
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = (PW > nps_pkg::DIST_W + 1) ? PW : nps_pkg::DIST_W + 1;

  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  logic [DW-1:0] adx;
  logic [DW-1:0] ady;

  nps_pkg::scan_tag_t s1_tag_r, s2_tag_r, s3_tag_r;
  logic [IDX_W-1:0]   s1_idx_r, s2_idx_r, s3_idx_r;
  logic [DW-1:0]      s1_adx_r, s1_ady_r;
  logic [PW-1:0]      s2_sqx_r, s2_sqy_r;
  logic               s2_ovx_r, s2_ovy_r;
  logic [nps_pkg::DIST_W-1:0] s3_dist_r;

  logic [nps_pkg::DIST_W-1:0] satx;
  logic [nps_pkg::DIST_W-1:0] saty;
  logic [nps_pkg::DIST_W:0]   sum;

  // Differences in one extra bit so they never wrap.
  assign dx  = {qx[COORD_WIDTH-1], qx} - {px[COORD_WIDTH-1], px};
  assign dy  = {qy[COORD_WIDTH-1], qy} - {py[COORD_WIDTH-1], py};
  assign adx = dx[DW-1] ? (~dx + 1'b1) : dx;
  assign ady = dy[DW-1] ? (~dy + 1'b1) : dy;

  assign satx = (s2_ovx_r || (XW'(s2_sqx_r) > XW'(nps_pkg::DIST_MAX))) ?
                nps_pkg::DIST_MAX : nps_pkg::DIST_W'(s2_sqx_r);
  assign saty = (s2_ovy_r || (XW'(s2_sqy_r) > XW'(nps_pkg::DIST_MAX))) ?
                nps_pkg::DIST_MAX : nps_pkg::DIST_W'(s2_sqy_r);
  assign sum  = {1'b0, satx} + {1'b0, saty};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= idx_in;
    s1_adx_r  <= adx;
    s1_ady_r  <= ady;
    s2_idx_r  <= s1_idx_r;
    s2_sqx_r  <= s1_adx_r * s1_adx_r;
    s2_sqy_r  <= s1_ady_r * s1_ady_r;
    s2_ovx_r  <= XW'(s1_adx_r) > XW'(nps_pkg::DIFF_LIM);
    s2_ovy_r  <= XW'(s1_ady_r) > XW'(nps_pkg::DIFF_LIM);
    s3_idx_r  <= s2_idx_r;
    s3_dist_r <= (sum > {1'b0, nps_pkg::DIST_MAX}) ? nps_pkg::DIST_MAX :
                 sum[nps_pkg::DIST_W-1:0];
  end

  assign tag_out  = s3_tag_r;
  assign idx_out  = s3_idx_r;
  assign dist_out = s3_dist_r;

endmodule

`default_nettype wire

// ----- dv/nearest_point_search_tb.sv -----
// Self-checking testbench for the nearest point search block.
`timescale 1ns / 1ps

module nearest_point_search_tb;

  // Cycles to let pass once the last expected result has come. A query scans
  // every active slot and then runs through a short distance pipeline.
  localparam int unsigned SETTLE_CYCLES = nps_pkg::MAX_POINTS_DEF + 16;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_BEATS   = 85;

  // Byte addresses on the configuration port. Index one holds no register.
  localparam logic [nps_pkg::REG_IDX_W-1:0]  REG_UNUSED  = 1'b1;
  localparam logic [nps_pkg::APB_ADDR_W-1:0] ADDR_COUNT  = {nps_pkg::REG_POINT_COUNT, 2'b00};
  localparam logic [nps_pkg::APB_ADDR_W-1:0] ADDR_UNUSED = {REG_UNUSED, 2'b00};

  // One row of the directed table. When set_cnt is high, point_count is
  // written (with the block idle) before the beat goes out. When pinned is
  // high the result is checked against the value typed into the row.
  typedef struct {
    bit                          set_cnt;
    logic [nps_pkg::COUNT_W-1:0] cnt;
    nps_pkg::in_item_t           beat;
    bit                          pinned;
    nps_pkg::out_item_t          want;
  } dir_row_t;

  // Travels with each beat from the driver to the prediction block.
  typedef struct {
    bit                 on;
    nps_pkg::out_item_t val;
  } pinned_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  nps_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  nps_pkg::out_item_t out_data;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [nps_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [nps_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [nps_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // Mirror of the block's state, kept up to date from the accepted beats.
  // Slots start at the origin so that picks near them are always defined.
  logic signed [nps_pkg::FIELD_W-1:0] store_x [nps_pkg::MAX_POINTS_DEF] = '{default: '0};
  logic signed [nps_pkg::FIELD_W-1:0] store_y [nps_pkg::MAX_POINTS_DEF] = '{default: '0};
  logic [nps_pkg::COUNT_W-1:0]        count_mirror = nps_pkg::POINT_COUNT_RST;

  nps_pkg::out_item_t nearest_q [$];   // Nearest-point results still owed by the block.
  pinned_t            typed_q [$];     // Typed expectations, one entry per beat sent.
  dir_row_t           dir_rows [$];

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int unsigned rx_left = 0;

  int unsigned err_cnt = 0;
  int unsigned n_writes = 0;
  int unsigned n_queries = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;

  nearest_point_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Predicts the nearest slot and its squared distance for a query position,
  // scanning the mirrored store the way the block does. The comparison is
  // strict, so the lowest slot wins a tie. A count of zero acts as one and a
  // count above the store size acts as the store size.
  function automatic nps_pkg::out_item_t nearest_point(
      input logic signed [nps_pkg::FIELD_W-1:0] qx,
      input logic signed [nps_pkg::FIELD_W-1:0] qy);
    nps_pkg::out_item_t best;
    int unsigned        span;
    longint             dx;
    longint             dy;
    longint unsigned    d;
    longint unsigned    best_d;
    span = count_mirror;
    if (span == 0) span = 1;
    if (span > nps_pkg::MAX_POINTS_DEF) span = nps_pkg::MAX_POINTS_DEF;
    best_d = 0;
    best.nearest_slot = '0;
    for (int unsigned i = 0; i < span; i++) begin
      dx = longint'(qx) - longint'(store_x[i]);
      dy = longint'(qy) - longint'(store_y[i]);
      d = longint'(dx * dx) + longint'(dy * dy);
      if (d > longint'(nps_pkg::DIST_MAX)) d = longint'(nps_pkg::DIST_MAX);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best.nearest_slot = nps_pkg::SLOT_W'(i);
      end
    end
    best.nearest_dist_sq = nps_pkg::DIST_W'(best_d);
    return best;
  endfunction

  // Picks one coordinate. Most picks land near a given stored coordinate or
  // in a tight cluster around the origin, which produces exact hits and ties;
  // the rest cover the full signed range and its extremes.
  function automatic logic [nps_pkg::FIELD_W-1:0] coord_pick(
      input logic [nps_pkg::FIELD_W-1:0] near);
    logic [nps_pkg::FIELD_W-1:0] v;
    case ($urandom_range(0, 11))
      0, 1:    v = near;
      2, 3, 4: v = near + nps_pkg::FIELD_W'($urandom_range(0, 32)) - nps_pkg::FIELD_W'(16);
      5, 6, 7: v = nps_pkg::FIELD_W'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = nps_pkg::FIELD_W'($urandom_range(0, 40)) - nps_pkg::FIELD_W'(20);
    endcase
    return v;
  endfunction

  // Random sender gap: mostly none or short, now and then long.
  function automatic int unsigned tx_gap();
    int unsigned r;
    if (!tx_idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one beat on the input channel. Valid is only lowered when a gap
  // is wanted, so back-to-back beats keep it high through the edge.
  task automatic send_beat(input nps_pkg::in_item_t beat, input bit pinned,
                           input nps_pkg::out_item_t want);
    int unsigned gap;
    pinned_t     pin;
    gap = tx_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.on = pinned;
    pin.val = want;
    typed_q.push_back(pin);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every owed result has come, then lets the
  // block finish any scan that owes nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each transfer ends with an idle bus state so the next one starts cleanly.
  task automatic apb_write(input logic [nps_pkg::APB_ADDR_W-1:0] addr,
                           input logic [nps_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [nps_pkg::APB_ADDR_W-1:0] addr,
                          output logic [nps_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes point_count with junk in the unused upper bits and reads it back.
  task automatic set_point_count(input logic [nps_pkg::COUNT_W-1:0] value);
    logic [nps_pkg::APB_DATA_W-1:0] got;
    logic [nps_pkg::APB_DATA_W-1:0] want;
    want = {{(nps_pkg::APB_DATA_W - nps_pkg::COUNT_W){1'b0}}, value};
    apb_write(ADDR_COUNT,
              {$urandom} & ~{{(nps_pkg::APB_DATA_W - nps_pkg::COUNT_W){1'b0}},
                             {nps_pkg::COUNT_W{1'b1}}}
              | want);
    apb_read(ADDR_COUNT, got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: point_count readback expected %0d, got %0d", $time, want, got);
    end
    n_settings++;
  endtask

  task automatic add_row(input bit set_cnt, input int cnt, input logic kind,
                         input int slot, input int x, input int y,
                         input bit pinned, input int eslot, input longint edist);
    dir_row_t r;
    r.set_cnt = set_cnt;
    r.cnt = nps_pkg::COUNT_W'(cnt);
    r.beat.kind = kind;
    r.beat.slot = nps_pkg::SLOT_W'(slot);
    r.beat.coord_x = nps_pkg::FIELD_W'(x);
    r.beat.coord_y = nps_pkg::FIELD_W'(y);
    r.pinned = pinned;
    r.want.nearest_slot = nps_pkg::SLOT_W'(eslot);
    r.want.nearest_dist_sq = nps_pkg::DIST_W'(edist);
    dir_rows.push_back(r);
  endtask

  // Prediction: follows register writes and accepted input beats. A write
  // beat updates the mirrored store; a query owes one result, either the
  // value typed into its directed row or the predicted one.
  always @(posedge clk) begin : predict
    pinned_t            pin;
    nps_pkg::out_item_t guess;
    if (rst_n) begin
      if (psel && penable && pwrite && pready &&
          paddr[nps_pkg::APB_ADDR_W-1:2] == nps_pkg::REG_POINT_COUNT) begin
        count_mirror = pwdata[nps_pkg::COUNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        pin = typed_q.pop_front();
        if (in_data.kind == nps_pkg::KIND_WRITE) begin
          store_x[in_data.slot] = in_data.coord_x;
          store_y[in_data.slot] = in_data.coord_y;
          n_writes++;
        end else begin
          guess = nearest_point(in_data.coord_x, in_data.coord_y);
          nearest_q.push_back(pin.on ? pin.val : guess);
          n_queries++;
        end
      end
    end
  end

  // Checking: every accepted result beat is held against the oldest owed one.
  always @(posedge clk) begin : check
    nps_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (nearest_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, got slot %0d dist %0d", $time,
                 out_data.nearest_slot, out_data.nearest_dist_sq);
      end else begin
        want = nearest_q.pop_front();
        if (out_data.nearest_slot !== want.nearest_slot) begin
          err_cnt++;
          $display("%0t: nearest_slot expected %0d, got %0d", $time,
                   want.nearest_slot, out_data.nearest_slot);
        end
        if (out_data.nearest_dist_sq !== want.nearest_dist_sq) begin
          err_cnt++;
          $display("%0t: nearest_dist_sq expected %0d, got %0d", $time,
                   want.nearest_dist_sq, out_data.nearest_dist_sq);
        end
      end
    end
  end

  // Receiver: alternates ready runs with stalls, mostly short with an
  // occasional long one. With idling off, ready stays high.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!rx_idling) begin
      out_ready <= 1'b1;
      rx_left <= 0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      rx_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
      rx_left <= $urandom_range(0, 12);
    end
  end

  // The timeout allows several times the slowest correct run before the run is
  // declared hung.
  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [nps_pkg::COUNT_W-1:0]    phase_counts [NUM_PHASES];
    logic [nps_pkg::APB_DATA_W-1:0] rd;
    nps_pkg::in_item_t              beat;
    int unsigned                    s;

    phase_counts = '{7'd64, 7'd127, 7'd17, 7'd2, 7'd1, 7'd0, 7'd40, 7'd64};

    // Directed part. Slot zero starts as the only active slot, so the first
    // queries show the reset value of point_count: slot one is closer but
    // must not be scanned. The squared distance across the whole coordinate
    // range is the largest the block can report.
    add_row(0, 0, nps_pkg::KIND_WRITE,  0, -32768, -32768, 0, 0, 0);
    add_row(0, 0, nps_pkg::KIND_WRITE,  1,      0,      0, 0, 0, 0);
    add_row(0, 0, nps_pkg::KIND_QUERY,  0,  32767,  32767, 1, 0, 64'd8589672450);
    add_row(0, 0, nps_pkg::KIND_QUERY, 63,      0,      0, 1, 0, 64'd2147483648);
    add_row(0, 0, nps_pkg::KIND_QUERY,  0, -32768, -32768, 1, 0, 0);
    add_row(0, 0, nps_pkg::KIND_WRITE, 63,  32767,  32767, 0, 0, 0);
    add_row(0, 0, nps_pkg::KIND_WRITE,  2,      0,      0, 0, 0, 0);
    add_row(0, 0, nps_pkg::KIND_WRITE,  3,     16,     16, 0, 0, 0);
    // Four active slots; slots one and two hold the same point, so the tie
    // goes to slot one. Then three equal distances go to slot zero.
    add_row(1, 4, nps_pkg::KIND_QUERY,  0,      0,      0, 1, 1, 0);
    add_row(0, 0, nps_pkg::KIND_WRITE,  0,      0,      0, 0, 0, 0);
    add_row(0, 0, nps_pkg::KIND_QUERY,  5,      0,      0, 1, 0, 0);
    add_row(0, 0, nps_pkg::KIND_QUERY,  0,      8,      8, 1, 0, 128);
    add_row(0, 0, nps_pkg::KIND_QUERY,  0,     -1,     -1, 1, 0, 2);
    add_row(0, 0, nps_pkg::KIND_WRITE,  3, -32768,  32767, 0, 0, 0);
    add_row(0, 0, nps_pkg::KIND_QUERY,  0, -32768,  32767, 1, 3, 0);
    // A count of zero scans slot zero alone.
    add_row(1, 0, nps_pkg::KIND_QUERY,  0,     16,     16, 1, 0, 512);
    add_row(0, 0, nps_pkg::KIND_WRITE,  1,  32767, -32768, 0, 0, 0);
    add_row(1, 2, nps_pkg::KIND_QUERY,  0,  32767, -32768, 1, 1, 0);
    add_row(0, 0, nps_pkg::KIND_QUERY, 42,      1,     -1, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cnt) begin
        settle();
        set_point_count(dir_rows[i].cnt);
      end
      send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);
    end
    settle();

    // Fill every slot so that any point_count setting scans written points.
    for (int i = 0; i < nps_pkg::MAX_POINTS_DEF; i++) begin
      s = $urandom_range(0, nps_pkg::MAX_POINTS_DEF - 1);
      beat.kind = nps_pkg::KIND_WRITE;
      beat.slot = nps_pkg::SLOT_W'(i);
      beat.coord_x = coord_pick(store_x[s]);
      beat.coord_y = coord_pick(store_y[s]);
      send_beat(beat, 1'b0, '0);
    end

    // Random phases, one point_count setting each, extremes included. One
    // phase runs with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_point_count(phase_counts[p]);
      if (p == 2) begin
        // A write to the empty register index must leave point_count alone.
        apb_write(ADDR_UNUSED, 32'h5);
        apb_read(ADDR_COUNT, rd);
        if (rd !== {{(nps_pkg::APB_DATA_W - nps_pkg::COUNT_W){1'b0}}, count_mirror}) begin
          err_cnt++;
          $display("%0t: point_count after unused write expected %0d, got %0d",
                   $time, count_mirror, rd);
        end
      end
      tx_idling = (p != 2);
      rx_idling = (p != 2 && p != 6);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Mid-phase, hold the sender until the block has caught up.
        if ((p == 0 || p == 3) && n == PHASE_BEATS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (nearest_q.size() != 0) @(posedge clk);
        end
        s = $urandom_range(0, nps_pkg::MAX_POINTS_DEF - 1);
        beat.kind = ($urandom_range(0, 99) < 35) ? nps_pkg::KIND_WRITE : nps_pkg::KIND_QUERY;
        beat.slot = nps_pkg::SLOT_W'($urandom);
        beat.coord_x = coord_pick(store_x[s]);
        beat.coord_y = coord_pick(store_y[s]);
        send_beat(beat, 1'b0, '0);
      end
    end
    settle();

    $display("Run covered %0d write beats and %0d query beats over %0d point_count settings,",
             n_writes, n_queries, n_settings);
    $display("with %0d result beats checked and %0d mismatches.", n_results, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
